/* rtl/ihb_pkg.sv */
package ihb_pkg;

	localparam logic [3:0]  IP_VERSION  = 4'd4;
	localparam logic [3:0]  IP_IHL      = 4'd5;
	localparam logic [7:0]  IP_TOS      = 8'd0;
	localparam logic [7:0]  IP_TTL      = 8'd64;
	localparam logic [15:0] HDR_BYTES   = 16'd20;
	localparam logic [15:0] MAX_PAYLOAD = 16'd65515;
	localparam int          HDR_WORDS   = 5;
	localparam logic [2:0]  LAST_IDX    = 3'(HDR_WORDS - 1);

	typedef enum logic [1:0] {
		REG_LOCAL_ADDR   = 2'd0,
		REG_SUBNET_MASK  = 2'd1,
		REG_GATEWAY_ADDR = 2'd2,
		REG_LOOPBACK     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] payload_length;
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
	} pkt_in_t;

	typedef struct packed {
		logic [31:0] header_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic [31:0] next_hop_addr;
		logic        local_delivery;
		logic        length_error;
	} hdr_out_t;

	// one packet handed from the front register to the word emitter
	typedef struct packed {
		logic        length_error;
		logic [15:0] total_length;
		logic [15:0] ident;
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [31:0] next_hop_addr;
		logic        local_delivery;
	} hdr_job_t;

	// one's-complement sum over the header halves, checksum field taken as zero
	function automatic logic [15:0] ihb_checksum(input hdr_job_t job);
		logic [18:0] sum;
		logic [16:0] fold1;
		logic [15:0] fold2;
		sum = 19'({IP_VERSION, IP_IHL, IP_TOS}) + 19'(job.total_length)
			+ 19'(job.ident) + 19'({IP_TTL, job.protocol})
			+ 19'(job.src_addr[31:16]) + 19'(job.src_addr[15:0])
			+ 19'(job.dst_addr[31:16]) + 19'(job.dst_addr[15:0]);
		fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
		fold2 = fold1[15:0] + 16'(fold1[16]);
		return ~fold2;
	endfunction

endpackage

/* rtl/ihb_stream_if.sv */
interface ihb_in_if;
	logic              valid;
	logic              ready;
	ihb_pkg::pkt_in_t  payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface ihb_out_if;
	logic              valid;
	logic              ready;
	ihb_pkg::hdr_out_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* rtl/ipv4_header_builder.sv */
// channel   | dir | transaction
// ----------+-----+------------------------------------------------------------
// pkt_in    | in  | one packet: payload length, protocol, source, destination
// hdr_out   | out | one header word with index, last flag, next hop, flags
// cfg_*     | in  | one register write per cycle with cfg_we high, no read-back
//
// a packet leaves as five header words, one per output transfer, built by
// the word emitter. an oversized payload gives a single error word instead.
// a new packet is taken into the front register while the previous one is
// still leaving, so packets stream back to back.
// a stall on hdr_out holds the current word; pkt_in fills the front register
// and then waits. arst_n clears the ident counter, config registers, word index and valid flags.
module ipv4_header_builder (
	input  logic        clk,
	input  logic        arst_n,
	ihb_in_if.sink      pkt_in,
	ihb_out_if.source   hdr_out,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	import ihb_pkg::*;

	// interface configuration
	logic [31:0] local_addr_q;
	logic [31:0] subnet_mask_q;
	logic [31:0] gateway_addr_q;
	logic        loopback_q;

	// identification counter, bumped per good packet
	logic [15:0] ident_q;

	// front register
	logic        job_valid_s1;
	hdr_job_t    job_s1;
	logic        job_ready;

	logic        in_fire;
	logic        len_err;
	logic        on_subnet;
	logic [15:0] ident_next;
	pkt_in_t     pkt;

	assign pkt          = pkt_in.payload;
	assign pkt_in.ready = !job_valid_s1 || job_ready;
	assign in_fire      = pkt_in.valid && pkt_in.ready;
	assign len_err      = pkt.payload_length > MAX_PAYLOAD;
	assign ident_next   = ident_q + 16'd1;
	assign on_subnet    = (local_addr_q & subnet_mask_q) == (pkt.dst_addr & subnet_mask_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q   <= '0;
			subnet_mask_q  <= '0;
			gateway_addr_q <= '0;
			loopback_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOCAL_ADDR:   local_addr_q   <= cfg_wdata;
				REG_SUBNET_MASK:  subnet_mask_q  <= cfg_wdata;
				REG_GATEWAY_ADDR: gateway_addr_q <= cfg_wdata;
				REG_LOOPBACK:     loopback_q     <= cfg_wdata[0];
				default:          ;
			endcase
		end
	end

	// error packets leave the counter alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q <= '0;
		end else if (in_fire && !len_err) begin
			ident_q <= ident_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (in_fire) begin
			job_valid_s1 <= 1'b1;
		end else if (job_ready) begin
			job_valid_s1 <= 1'b0;
		end
	end

	// route decision and length made here, checksum in the emitter
	always_ff @(posedge clk) begin
		if (in_fire) begin
			job_s1.length_error   <= len_err;
			job_s1.total_length   <= pkt.payload_length + HDR_BYTES;
			job_s1.ident          <= ident_next;
			job_s1.protocol       <= pkt.protocol;
			job_s1.src_addr       <= pkt.src_addr;
			job_s1.dst_addr       <= pkt.dst_addr;
			job_s1.local_delivery <= loopback_q;
			job_s1.next_hop_addr  <= (loopback_q || on_subnet) ? pkt.dst_addr : gateway_addr_q;
		end
	end

	ihb_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid_s1),
		.job       (job_s1),
		.job_ready (job_ready),
		.hdr_out   (hdr_out)
	);

endmodule

/* rtl/ihb_emitter.sv */
module ihb_emitter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  ihb_pkg::hdr_job_t job,
	output logic              job_ready,
	ihb_out_if.source         hdr_out
);
	import ihb_pkg::*;

	logic [31:0] words_q [HDR_WORDS];
	logic [2:0]  idx_q;
	logic        busy_q;
	logic        err_q;
	logic [31:0] hop_q;
	logic        local_q;

	logic        out_fire;
	logic        last;
	logic        load;
	logic [15:0] csum;

	assign out_fire  = hdr_out.valid && hdr_out.ready;
	assign last      = err_q || (idx_q == LAST_IDX);
	assign job_ready = !busy_q || (out_fire && last);
	assign load      = job_valid && job_ready;
	assign csum      = ihb_checksum(job);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_fire && last) begin
			busy_q <= 1'b0;
		end else if (out_fire) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	// word shift line: entry 0 is always the head
	always_ff @(posedge clk) begin
		if (load) begin
			err_q   <= job.length_error;
			hop_q   <= job.length_error ? '0 : job.next_hop_addr;
			local_q <= job.length_error ? 1'b0 : job.local_delivery;
			if (job.length_error) begin
				for (int k = 0; k < HDR_WORDS; k++) begin
					words_q[k] <= '0;
				end
			end else begin
				words_q[0] <= {IP_VERSION, IP_IHL, IP_TOS, job.total_length};
				words_q[1] <= {job.ident, 16'h0000};
				words_q[2] <= {IP_TTL, job.protocol, csum};
				words_q[3] <= job.src_addr;
				words_q[4] <= job.dst_addr;
			end
		end else if (out_fire) begin
			for (int k = 0; k < HDR_WORDS - 1; k++) begin
				words_q[k] <= words_q[k + 1];
			end
		end
	end

	assign hdr_out.valid                  = busy_q;
	assign hdr_out.payload.header_word    = words_q[0];
	assign hdr_out.payload.word_index     = idx_q;
	assign hdr_out.payload.last_word      = last;
	assign hdr_out.payload.next_hop_addr  = hop_q;
	assign hdr_out.payload.local_delivery = local_q;
	assign hdr_out.payload.length_error   = err_q;

endmodule

/* rtl/ihb_checker.sv */
module ihb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] header_word,
	input logic [2:0]  word_index,
	input logic        last_word,
	input logic        length_error
);
	import ihb_pkg::*;

	// a stalled word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(header_word)
			&& $stable(word_index))
		else $error("stalled header word changed");

	// words of one packet follow without a gap, in order
	a_word_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=>
			out_valid && (word_index == $past(word_index) + 3'd1))
		else $error("header word sequence broken");

	// a packet that directly follows a last word starts at word zero
	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_word |=> !out_valid || (word_index == 3'd0))
		else $error("packet does not start at word zero");

	// error result is a single zero word
	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_error |->
			last_word && (word_index == 3'd0) && (header_word == 32'd0))
		else $error("malformed length error result");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_word == (length_error || (word_index == LAST_IDX)))
		else $error("last word flag wrong");

endmodule

bind ipv4_header_builder ihb_checker u_ihb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (hdr_out.valid),
	.out_ready    (hdr_out.ready),
	.header_word  (hdr_out.payload.header_word),
	.word_index   (hdr_out.payload.word_index),
	.last_word    (hdr_out.payload.last_word),
	.length_error (hdr_out.payload.length_error)
);
